/* hw/rtl/gbns_pkg.sv */
// shared types, constants and the control program of the go-back-n sender window
package gbns_pkg;

  // sizes
  localparam int SEQ_BITS      = 16;
  localparam int TIME_BITS     = 32;
  localparam int STAMP_SLOTS   = 16;
  localparam int SLOT_BITS     = $clog2(STAMP_SLOTS);
  localparam int MAX_SENDS     = 16;
  localparam int CNT_BITS      = $clog2(MAX_SENDS + 1);
  localparam int LIMIT_BITS    = 4;
  localparam int KIND_BITS     = 2;
  localparam int TYPE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int STEP_BITS     = 4;
  localparam int IN_DATA_BITS  = ((SEQ_BITS + 7) / 8) * 8;
  localparam int OUT_USED_BITS = 3 + 2 * SEQ_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // register reset values
  localparam logic [SEQ_BITS-1:0]   FIRST_SEQ_RST = SEQ_BITS'(1);
  localparam logic [SEQ_BITS-1:0]   SEG_TOTAL_RST = SEQ_BITS'(1);
  localparam logic [LIMIT_BITS-1:0] WIN_LIMIT_RST = LIMIT_BITS'(10);
  localparam logic [SEQ_BITS-1:0]   TIMEOUT_RST   = SEQ_BITS'(1000);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_TICK  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [TYPE_BITS-1:0] {
    SEG_NAME  = 2'd0,
    SEG_DATA  = 2'd1,
    SEG_FINAL = 2'd2
  } seg_type_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_SEQ = 3'd0,
    CFG_SEG_TOTAL = 3'd1,
    CFG_WIN_LIMIT = 3'd2,
    CFG_TIMEOUT   = 3'd3
  } cfg_idx_e;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_CLEAR,
    OP_TIME_INC,
    OP_CHECK,
    OP_SEND,
    OP_REWIND,
    OP_ACK,
    OP_START
  } op_e;

  // result word loaded into the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_STATUS,
    EMIT_DONE,
    EMIT_SEND
  } emit_e;

  // branch condition: taken goes to target (for COND_KIND to the step of the kind), else to the next step
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_IDLE,
    COND_KIND,
    COND_DONE,
    COND_NO_SEND,
    COND_MORE,
    COND_SENT
  } cond_e;

  // step addresses
  typedef enum logic [STEP_BITS-1:0] {
    ST_FETCH    = 4'd0,
    ST_DISPATCH = 4'd1,
    ST_TICK     = 4'd2,
    ST_CHECK    = 4'd3,
    ST_PRESEND  = 4'd4,
    ST_SEND     = 4'd5,
    ST_REWIND   = 4'd6,
    ST_STATUS   = 4'd7,
    ST_DONE     = 4'd8,
    ST_ACK      = 4'd9,
    ST_START    = 4'd10,
    ST_REPORT   = 4'd11
  } step_e;

  typedef struct packed {
    logic  take;
    op_e   op;
    emit_e emit;
    cond_e cond;
    step_e target;
  } ctrl_t;

  typedef struct packed {
    logic                 accept;
    logic [KIND_BITS-1:0] kind;
    logic                 fire;
    logic                 done;
    logic                 can_send;
    logic                 more;
    logic                 sent;
  } status_t;

  // control program
  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_t c;
    c = '{take: 1'b0, op: OP_NOP, emit: EMIT_NONE, cond: COND_ALWAYS, target: ST_FETCH};
    case (step)
      ST_FETCH:    c = '{1'b1, OP_LATCH,    EMIT_NONE,   COND_IDLE,    ST_FETCH};
      ST_DISPATCH: c = '{1'b0, OP_CLEAR,    EMIT_NONE,   COND_KIND,    ST_REPORT};
      ST_TICK:     c = '{1'b0, OP_TIME_INC, EMIT_NONE,   COND_NEXT,    ST_FETCH};
      ST_CHECK:    c = '{1'b0, OP_CHECK,    EMIT_NONE,   COND_DONE,    ST_DONE};
      ST_PRESEND:  c = '{1'b0, OP_NOP,      EMIT_NONE,   COND_NO_SEND, ST_REWIND};
      ST_SEND:     c = '{1'b0, OP_SEND,     EMIT_SEND,   COND_MORE,    ST_SEND};
      ST_REWIND:   c = '{1'b0, OP_REWIND,   EMIT_NONE,   COND_SENT,    ST_FETCH};
      ST_STATUS:   c = '{1'b0, OP_NOP,      EMIT_STATUS, COND_ALWAYS,  ST_FETCH};
      ST_DONE:     c = '{1'b0, OP_NOP,      EMIT_DONE,   COND_ALWAYS,  ST_FETCH};
      ST_ACK:      c = '{1'b0, OP_ACK,      EMIT_NONE,   COND_ALWAYS,  ST_REPORT};
      ST_START:    c = '{1'b0, OP_START,    EMIT_NONE,   COND_NEXT,    ST_FETCH};
      ST_REPORT:   c = '{1'b0, OP_NOP,      EMIT_STATUS, COND_ALWAYS,  ST_FETCH};
      default:     c = '{1'b0, OP_NOP,      EMIT_NONE,   COND_ALWAYS,  ST_FETCH};
    endcase
    return c;
  endfunction

  // dispatch on the kind of the latched word
  function automatic step_e kind_target(input logic [KIND_BITS-1:0] kind);
    step_e s;
    case (kind)
      KIND_TICK:  s = ST_TICK;
      KIND_ACK:   s = ST_ACK;
      KIND_START: s = ST_START;
      default:    s = ST_REPORT;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/gbns_ram.sv */
// generic single write port ram with registered read
module gbns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/gbns_sequencer.sv */
// step counter, control store and branch logic
module gbns_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbns_pkg::status_t status_i,
  output gbns_pkg::ctrl_t   ctrl_o
);

  logic [gbns_pkg::STEP_BITS-1:0] step_q, step_d;
  gbns_pkg::ctrl_t                ctrl;
  logic                           taken;
  logic [gbns_pkg::STEP_BITS-1:0] dest;

  assign ctrl = gbns_pkg::ucode(step_q);

  // branch condition select
  always_comb begin
    taken = 1'b0;
    dest  = ctrl.target;
    case (ctrl.cond)
      gbns_pkg::COND_NEXT:    taken = 1'b0;
      gbns_pkg::COND_ALWAYS:  taken = 1'b1;
      gbns_pkg::COND_IDLE:    taken = !status_i.accept;
      gbns_pkg::COND_KIND: begin
        taken = 1'b1;
        dest  = gbns_pkg::kind_target(status_i.kind);
      end
      gbns_pkg::COND_DONE:    taken = status_i.done;
      gbns_pkg::COND_NO_SEND: taken = !status_i.can_send;
      gbns_pkg::COND_MORE:    taken = status_i.more;
      gbns_pkg::COND_SENT:    taken = status_i.sent;
      default:                taken = 1'b0;
    endcase
  end

  // next step, held while a step that loads the output register finds it full and not ready
  always_comb begin
    step_d = step_q;
    if (status_i.fire) begin
      step_d = taken ? dest : step_q + gbns_pkg::STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= gbns_pkg::ST_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

/* hw/rtl/gbns_datapath.sv */
// window registers, stamp store, configuration and output register
module gbns_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gbns_pkg::ctrl_t                      ctrl_i,
  output gbns_pkg::status_t                    status_o,
  input  logic                                 s_tvalid_i,
  input  logic [gbns_pkg::IN_DATA_BITS-1:0]    s_tdata_i,
  input  logic [gbns_pkg::KIND_BITS-1:0]       s_tuser_i,
  input  logic                                 cfg_valid_i,
  input  logic [gbns_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [gbns_pkg::SEQ_BITS-1:0]        cfg_data_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [gbns_pkg::OUT_DATA_BITS-1:0]   m_tdata_o,
  output logic [gbns_pkg::TYPE_BITS-1:0]       m_tuser_o,
  output logic                                 m_tlast_o
);

  localparam int SB = gbns_pkg::SEQ_BITS;
  localparam int TB = gbns_pkg::TIME_BITS;
  localparam int LB = gbns_pkg::SLOT_BITS;
  localparam int CB = gbns_pkg::CNT_BITS;

  // configuration registers
  logic [SB-1:0]                   first_q, total_q, timeout_q;
  logic [gbns_pkg::LIMIT_BITS-1:0] limit_q;

  // window state
  logic [gbns_pkg::KIND_BITS-1:0] kind_q;
  logic [SB-1:0]                  ack_q, base_q, base_d, nts_q, nts_d;
  logic [TB-1:0]                  time_q, time_d;
  logic [LB-1:0]                  head_q, head_d;
  logic [CB-1:0]                  n_q, n_d;
  logic                           tmo_q, tmo_d;

  // output register
  logic                            out_valid_q;
  logic                            out_send_q, out_done_q, out_tmo_q, out_last_q;
  logic [SB-1:0]                   out_seq_q, out_wstart_q;
  logic [gbns_pkg::TYPE_BITS-1:0]  out_type_q;

  logic                            accept, fire, load;
  logic [SB-1:0]                   outst, next_off, base_off, ack_off;
  logic                            can_now, can_next;
  logic [gbns_pkg::TYPE_BITS-1:0]  seg_type;
  logic [TB-1:0]                   head_stamp, age;
  logic                            stamp_we;
  logic [LB-1:0]                   stamp_waddr;

  // send window test
  function automatic logic can_send(input logic [SB-1:0] o, input logic [SB-1:0] noff,
                                    input logic [CB-1:0] n, input logic [SB-1:0] tot,
                                    input logic [gbns_pkg::LIMIT_BITS-1:0] lim);
    return (o <= SB'(lim)) && (o < SB'(gbns_pkg::STAMP_SLOTS)) && (noff < tot) &&
           (n < CB'(gbns_pkg::MAX_SENDS));
  endfunction

  assign accept   = ctrl_i.take && s_tvalid_i;
  assign fire     = (ctrl_i.emit == gbns_pkg::EMIT_NONE) || !out_valid_q || m_tready_i;
  assign load     = fire && (ctrl_i.emit != gbns_pkg::EMIT_NONE);

  assign outst    = nts_q - base_q;
  assign next_off = nts_q - first_q;
  assign base_off = base_q - first_q;
  assign ack_off  = ack_q - base_q;
  assign can_now  = can_send(outst, next_off, n_q, total_q, limit_q);
  assign can_next = can_send(outst + SB'(1), next_off + SB'(1), n_q + CB'(1),
                             total_q, limit_q);
  assign age      = time_q - head_stamp;

  // segment type, final wins over name
  always_comb begin
    if (next_off == total_q - SB'(1)) begin
      seg_type = gbns_pkg::SEG_FINAL;
    end else if (next_off == '0) begin
      seg_type = gbns_pkg::SEG_NAME;
    end else begin
      seg_type = gbns_pkg::SEG_DATA;
    end
  end

  // stamp store, read port always on the oldest outstanding slot
  assign stamp_we    = fire && (ctrl_i.op == gbns_pkg::OP_SEND);
  assign stamp_waddr = head_q + outst[LB-1:0];

  gbns_ram #(
    .WIDTH (TB),
    .DEPTH (gbns_pkg::STAMP_SLOTS)
  ) u_stamps (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (time_q),
    .raddr_i (head_q),
    .rdata_o (head_stamp)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= gbns_pkg::FIRST_SEQ_RST;
      total_q   <= gbns_pkg::SEG_TOTAL_RST;
      limit_q   <= gbns_pkg::WIN_LIMIT_RST;
      timeout_q <= gbns_pkg::TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gbns_pkg::CFG_FIRST_SEQ: first_q   <= cfg_data_i;
        gbns_pkg::CFG_SEG_TOTAL: total_q   <= cfg_data_i;
        gbns_pkg::CFG_WIN_LIMIT: limit_q   <= cfg_data_i[gbns_pkg::LIMIT_BITS-1:0];
        gbns_pkg::CFG_TIMEOUT:   timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_tuser_i;
      ack_q  <= s_tdata_i[SB-1:0];
    end
  end

  // window operations
  always_comb begin
    base_d = base_q;
    nts_d  = nts_q;
    time_d = time_q;
    head_d = head_q;
    n_d    = n_q;
    tmo_d  = tmo_q;
    if (fire) begin
      case (ctrl_i.op)
        gbns_pkg::OP_CLEAR: begin
          n_d   = '0;
          tmo_d = 1'b0;
        end
        gbns_pkg::OP_TIME_INC: time_d = time_q + TB'(1);
        gbns_pkg::OP_CHECK: tmo_d = (outst != '0) && (age > TB'(timeout_q));
        gbns_pkg::OP_SEND: begin
          nts_d = nts_q + SB'(1);
          n_d   = n_q + CB'(1);
        end
        gbns_pkg::OP_REWIND: begin
          if (tmo_q) begin
            nts_d = base_q;
          end
        end
        gbns_pkg::OP_ACK: begin
          if (ack_off < outst) begin
            head_d = head_q + ack_off[LB-1:0] + LB'(1);
            base_d = ack_q + SB'(1);
          end
        end
        gbns_pkg::OP_START: begin
          base_d = first_q;
          nts_d  = first_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      nts_q  <= '0;
      time_q <= '0;
      head_q <= '0;
      n_q    <= '0;
      tmo_q  <= 1'b0;
    end else begin
      base_q <= base_d;
      nts_q  <= nts_d;
      time_q <= time_d;
      head_q <= head_d;
      n_q    <= n_d;
      tmo_q  <= tmo_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_wstart_q <= base_q;
      case (ctrl_i.emit)
        gbns_pkg::EMIT_SEND: begin
          out_send_q <= 1'b1;
          out_seq_q  <= nts_q;
          out_type_q <= seg_type;
          out_done_q <= 1'b0;
          out_tmo_q  <= tmo_q && !can_next;
          out_last_q <= !can_next;
        end
        gbns_pkg::EMIT_DONE: begin
          out_send_q <= 1'b0;
          out_seq_q  <= '0;
          out_type_q <= '0;
          out_done_q <= 1'b1;
          out_tmo_q  <= 1'b0;
          out_last_q <= 1'b1;
        end
        default: begin
          out_send_q <= 1'b0;
          out_seq_q  <= '0;
          out_type_q <= '0;
          out_done_q <= 1'b0;
          out_tmo_q  <= tmo_q;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(gbns_pkg::OUT_DATA_BITS - gbns_pkg::OUT_USED_BITS)'(0),
                       out_wstart_q, out_tmo_q, out_done_q, out_seq_q, out_send_q};
  assign m_tuser_o  = out_type_q;
  assign m_tlast_o  = out_last_q;

  assign status_o = '{accept:   accept,
                      kind:     kind_q,
                      fire:     fire,
                      done:     base_off >= total_q,
                      can_send: can_now,
                      more:     can_next,
                      sent:     n_q != '0};

`ifndef SYNTHESIS
  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst <= SB'(gbns_pkg::STAMP_SLOTS))
    else $error("outstanding span exceeds stamp slots");

  a_send_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CB'(gbns_pkg::MAX_SENDS))
    else $error("send count exceeds limit");

  a_send_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ctrl_i.emit == gbns_pkg::EMIT_SEND) |-> can_now)
    else $error("send issued outside the window");

  a_tmo_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tmo_q) |-> out_last_q)
    else $error("timeout flag on a word that is not last");

  a_stamp_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stamp_we |=> $stable(time_q))
    else $error("time moved during a send burst");
`endif

endmodule

/* hw/rtl/go_back_n_sender_window_top.sv */
// top level of the go-back-n sender window
//
//  channel  dir  handshake                fields
//  s_*      in   s_tvalid_i / s_tready_o  tuser kind, tdata ack_number
//  m_*      out  m_tvalid_o / m_tready_i  tdata status and sequence, tuser type, tlast
//  cfg_*    in   cfg_valid_i / cfg_ready_o cfg_index_i register, cfg_data_i value
//
// a tick runs fetch, dispatch, tick, check, presend, send (up to 16 sends, one per
// cycle while not held), rewind and, if it sent nothing, status; a done tick goes
// from check to done; ack and start words run their own step, then report, and an
// unused kind goes straight to report; the step counter moves one step per cycle
// unless a step holds; the output register lets a word wait while the program goes
// on; a step that must load a word holds while that register is full and m_tready_i
// is low; reset clears control state; the stamp store is only read at written slots

module go_back_n_sender_window_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  // [15:0] ack_number
  input  logic [gbns_pkg::IN_DATA_BITS-1:0]    s_tdata_i,
  // [1:0] kind
  input  logic [gbns_pkg::KIND_BITS-1:0]       s_tuser_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  // [0] send_valid, [16:1] seq_number, [17] all_done, [18] timed_out,
  // [34:19] window_start, [39:35] zero
  output logic [gbns_pkg::OUT_DATA_BITS-1:0]   m_tdata_o,
  // [1:0] segment_type
  output logic [gbns_pkg::TYPE_BITS-1:0]       m_tuser_o,
  output logic                                 m_tlast_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gbns_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [gbns_pkg::SEQ_BITS-1:0]        cfg_data_i
);

  gbns_pkg::ctrl_t   ctrl;
  gbns_pkg::status_t status;

  // control program
  gbns_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // datapath
  gbns_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .s_tvalid_i  (s_tvalid_i),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  assign s_tready_o  = ctrl.take;
  assign cfg_ready_o = 1'b1;

endmodule

/* test/gbns_window_checker.sv */
`timescale 1ns / 100ps
// checker that predicts and compares the result words of the go-back-n sender window
module gbns_window_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  input  logic                               s_tready_i,
  // [15:0] ack_number
  input  logic [gbns_pkg::IN_DATA_BITS-1:0]  s_tdata_i,
  // [1:0] kind
  input  logic [gbns_pkg::KIND_BITS-1:0]     s_tuser_i,
  input  logic                               m_tvalid_i,
  input  logic                               m_tready_i,
  // [0] send_valid, [16:1] seq_number, [17] all_done, [18] timed_out,
  // [34:19] window_start, [39:35] zero
  input  logic [gbns_pkg::OUT_DATA_BITS-1:0] m_tdata_i,
  // [1:0] segment_type
  input  logic [gbns_pkg::TYPE_BITS-1:0]     m_tuser_i,
  input  logic                               m_tlast_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [gbns_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [gbns_pkg::SEQ_BITS-1:0]      cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import gbns_pkg::*;

  typedef struct packed {
    logic                 send;
    logic [SEQ_BITS-1:0]  seq;
    logic [TYPE_BITS-1:0] stype;
    logic                 done;
    logic                 tmo;
    logic [SEQ_BITS-1:0]  base;
    logic                 lst;
  } gbn_word_t;

  // settings as the block holds them
  logic [SEQ_BITS-1:0]   first_seq;
  logic [SEQ_BITS-1:0]   seg_total;
  logic [LIMIT_BITS-1:0] win_limit;
  logic [SEQ_BITS-1:0]   timeout;

  // window state
  logic [SEQ_BITS-1:0]   base_seq;
  logic [SEQ_BITS-1:0]   next_seq;
  logic [TIME_BITS-1:0]  time_now;
  logic [TIME_BITS-1:0]  stamps [STAMP_SLOTS];
  logic [SLOT_BITS-1:0]  stamp_head;

  gbn_word_t expected_words [$];
  gbn_word_t got;
  gbn_word_t want;
  int        fail_total;

  function automatic gbn_word_t window_word(input logic send, input logic [SEQ_BITS-1:0] seq,
                                            input logic [TYPE_BITS-1:0] stype, input logic done,
                                            input logic tmo, input logic lst);
    gbn_word_t w;
    w = '{send: send, seq: seq, stype: stype, done: done, tmo: tmo, base: base_seq, lst: lst};
    return w;
  endfunction

  // append one expected word at the tail
  function automatic void add_word(input gbn_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic string word_text(input gbn_word_t w);
    return $sformatf("send %0b seq %h type %0d done %0b tmo %0b base %h last %0b",
                     w.send, w.seq, w.stype, w.done, w.tmo, w.base, w.lst);
  endfunction

  // expected words of one input word, window state moves along
  task automatic advance_window(input logic [KIND_BITS-1:0] kind,
                                input logic [SEQ_BITS-1:0] ack);
    logic [SEQ_BITS-1:0]  span;
    logic [SEQ_BITS-1:0]  ack_off;
    logic [SEQ_BITS-1:0]  base_off;
    logic [SEQ_BITS-1:0]  next_off;
    logic [TYPE_BITS-1:0] stype;
    logic [SLOT_BITS-1:0] slot;
    logic                 rewound;
    int                   sent;
    gbn_word_t            w;
    span    = next_seq - base_seq;
    rewound = 1'b0;
    sent    = 0;
    case (kind)
      KIND_START: begin
        base_seq = first_seq;
        next_seq = first_seq;
        add_word(window_word(1'b0, '0, SEG_NAME, 1'b0, 1'b0, 1'b1));
      end
      KIND_ACK: begin
        // cumulative ack counts only inside the outstanding span
        ack_off = ack - base_seq;
        if (ack_off < span) begin
          stamp_head = stamp_head + ack_off[SLOT_BITS-1:0] + 1'b1;
          base_seq   = ack + 1'b1;
        end
        add_word(window_word(1'b0, '0, SEG_NAME, 1'b0, 1'b0, 1'b1));
      end
      KIND_TICK: begin
        time_now = time_now + 1'b1;
        base_off = base_seq - first_seq;
        if (base_off >= seg_total) begin
          add_word(window_word(1'b0, '0, SEG_NAME, 1'b1, 1'b0, 1'b1));
        end else begin
          // burst of new segments while window and stamp store allow
          next_off = next_seq - first_seq;
          while (span <= win_limit && span < STAMP_SLOTS && next_off < seg_total &&
                 sent < MAX_SENDS) begin
            if (next_off == seg_total - 1'b1) begin
              stype = SEG_FINAL;
            end else if (next_off == '0) begin
              stype = SEG_NAME;
            end else begin
              stype = SEG_DATA;
            end
            slot         = stamp_head + span[SLOT_BITS-1:0];
            stamps[slot] = time_now;
            add_word(window_word(1'b1, next_seq, stype, 1'b0, 1'b0, 1'b0));
            next_seq = next_seq + 1'b1;
            next_off = next_off + 1'b1;
            span     = span + 1'b1;
            sent++;
          end
          // go back to the base once the oldest stamp is too old
          if (span != '0 && (time_now - stamps[stamp_head]) > timeout) begin
            next_seq = base_seq;
            rewound  = 1'b1;
          end
          if (sent == 0) begin
            add_word(window_word(1'b0, '0, SEG_NAME, 1'b0, rewound, 1'b1));
          end else begin
            w     = expected_words.pop_back();
            w.tmo = rewound;
            w.lst = 1'b1;
            add_word(w);
          end
        end
      end
      default: begin
        add_word(window_word(1'b0, '0, SEG_NAME, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seq  = FIRST_SEQ_RST;
      seg_total  = SEG_TOTAL_RST;
      win_limit  = WIN_LIMIT_RST;
      timeout    = TIMEOUT_RST;
      base_seq   = '0;
      next_seq   = '0;
      time_now   = '0;
      stamp_head = '0;
      for (int i = 0; i < STAMP_SLOTS; i++) stamps[i] = '0;
      expected_words.delete();
      fail_total   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FIRST_SEQ: first_seq = cfg_data_i;
          CFG_SEG_TOTAL: seg_total = cfg_data_i;
          CFG_WIN_LIMIT: win_limit = cfg_data_i[LIMIT_BITS-1:0];
          CFG_TIMEOUT:   timeout   = cfg_data_i;
          default: ;
        endcase
      end
      // result words against the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        got.send  = m_tdata_i[0];
        got.seq   = m_tdata_i[SEQ_BITS:1];
        got.stype = m_tuser_i;
        got.done  = m_tdata_i[SEQ_BITS+1];
        got.tmo   = m_tdata_i[SEQ_BITS+2];
        got.base  = m_tdata_i[2*SEQ_BITS+2:SEQ_BITS+3];
        got.lst   = m_tlast_i;
        if (expected_words.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) $display("%0t: word with nothing expected: %s", $time,
                                         word_text(got));
        end else begin
          want = expected_words.pop_front();
          if (got.send !== want.send || got.seq !== want.seq || got.stype !== want.stype ||
              got.done !== want.done || got.tmo !== want.tmo || got.base !== want.base ||
              got.lst !== want.lst) begin
            fail_total++;
            if (fail_total <= 10) $display("%0t: word mismatch\n  expected %s\n  actual   %s",
                                           $time, word_text(want), word_text(got));
          end
        end
      end
      // input words
      if (s_tvalid_i && s_tready_i) advance_window(s_tuser_i, s_tdata_i[SEQ_BITS-1:0]);
      fail_count_o <= fail_total;
      pending_o    <= expected_words.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// testbench top of the go-back-n sender window: clock, reset, stimulus and verdict
module tb_top;
  import gbns_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
  logic [KIND_BITS-1:0]     s_tuser   = '0;
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic [TYPE_BITS-1:0]     m_tuser;
  logic                     m_tlast;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [SEQ_BITS-1:0]      cfg_data  = '0;
  int                       fail_count;
  int                       pending;

  // stimulus steering
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  logic [SEQ_BITS-1:0] last_sent_seq = '0;
  int                  done_seen     = 0;
  int                  done_taken    = 0;

  go_back_n_sender_window_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .m_tuser_o   (m_tuser),
    .m_tlast_o   (m_tlast),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gbns_window_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // follow sends and done reports to steer acks and restarts
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (m_tdata[0]) last_sent_seq <= m_tdata[SEQ_BITS:1];
      if (m_tdata[SEQ_BITS+1]) done_seen <= done_seen + 1;
    end
  end

  task automatic put_word(input logic [KIND_BITS-1:0] kind, input logic [SEQ_BITS-1:0] ack);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= IN_DATA_BITS'(ack);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SEQ_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [SEQ_BITS-1:0] first, input logic [SEQ_BITS-1:0] total,
                           input logic [LIMIT_BITS-1:0] limit,
                           input logic [SEQ_BITS-1:0] ticks);
    write_reg(CFG_FIRST_SEQ, first);
    write_reg(CFG_SEG_TOTAL, total);
    // upper bits of the limit word carry noise
    write_reg(CFG_WIN_LIMIT, {12'($urandom), limit});
    write_reg(CFG_TIMEOUT, ticks);
    cfg_valid <= 1'b0;
  endtask

  // hold off until every result word is back and the block has settled
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random transfers: mostly ticks and acks near the newest send, restart after done
  task automatic run_phase(input int idle, input int stall, input logic [SEQ_BITS-1:0] first,
                           input logic [SEQ_BITS-1:0] total, input logic [LIMIT_BITS-1:0] limit,
                           input logic [SEQ_BITS-1:0] ticks, input int words);
    int pick;
    send_idle_pct = idle;
    stall_pct     = stall;
    configure(first, total, limit, ticks);
    done_taken = done_seen;
    put_word(KIND_START, '0);
    for (int i = 1; i < words; i++) begin
      pick = $urandom_range(99);
      if (done_seen != done_taken || pick < 3) begin
        done_taken = done_seen;
        put_word(KIND_START, 16'($urandom));
      end else if (pick < 50) begin
        put_word(KIND_TICK, 16'($urandom));
      end else if (pick < 88) begin
        put_word(KIND_ACK, last_sent_seq - 16'($urandom_range(0, 3)));
      end else if (pick < 94) begin
        put_word(KIND_ACK, first + 16'($urandom_range(total - 1)));
      end else if (pick < 97) begin
        put_word(KIND_ACK, 16'($urandom));
      end else begin
        put_word(KIND_UNUSED, 16'($urandom));
      end
    end
    wait_quiet();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: done before any start, stray ack, unused kind,
    // one segment that is both name and final
    put_word(KIND_TICK, '0);
    put_word(KIND_ACK, '0);
    put_word(KIND_UNUSED, 16'hFFFF);
    put_word(KIND_START, '0);
    put_word(KIND_TICK, '0);
    put_word(KIND_TICK, '0);
    put_word(KIND_ACK, 16'd1);
    put_word(KIND_TICK, '0);
    wait_quiet();

    // window across the top of sequence space, full bursts, rewind, acks out of window
    configure(16'hFFFF, 16'd20, 4'd15, 16'd2);
    put_word(KIND_START, '0);
    put_word(KIND_TICK, '0);
    put_word(KIND_TICK, '0);
    put_word(KIND_TICK, '0);
    put_word(KIND_TICK, '0);
    put_word(KIND_TICK, '0);
    put_word(KIND_ACK, 16'd18);
    put_word(KIND_ACK, 16'd14);
    put_word(KIND_TICK, '0);
    put_word(KIND_ACK, 16'hFFFF);
    put_word(KIND_ACK, 16'd18);
    put_word(KIND_TICK, '0);
    wait_quiet();

    run_phase(0, 0, 16'h0000, 16'd12, 4'd1, 16'd1, 48);
    run_phase(72, 0, 16'($urandom), 16'd40, 4'd15, 16'hFFFF, 48);
    run_phase(0, 72, 16'($urandom), 16'h8000, 4'd7, 16'd4, 48);
    run_phase(31, 31, 16'($urandom), 16'($urandom_range(1, 20)), 4'($urandom_range(1, 15)),
              16'($urandom_range(1, 8)), 48);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* go_back_n_sender_window_top.f */
hw/rtl/gbns_pkg.sv
hw/rtl/gbns_ram.sv
hw/rtl/gbns_sequencer.sv
hw/rtl/gbns_datapath.sv
hw/rtl/go_back_n_sender_window_top.sv
test/gbns_window_checker.sv
test/tb_top.sv
